### rtl/core/mesh_tangent_accumulator_assert.svh
// Assertion macros for the tangent accumulator
`ifndef MESH_TANGENT_ACCUMULATOR_ASSERT_SVH
`define MESH_TANGENT_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTA_ASSERT(label, clk, rst_n, prop, msg)
`define MTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/mta_pkg.sv
package mta_pkg;
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned FracBits = 16;
  localparam int unsigned SumW = 48;
  localparam int unsigned CntW = 16;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI = 2'd1,
    KIND_READ = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] vertex_index;
    logic [9:0] corner_b;
    logic [9:0] corner_c;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [9:0] read_index;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic [15:0] use_count;
    logic degenerate_seen;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD, ST_RDA, ST_RDB, ST_RDC, ST_DIFF, ST_MUL, ST_MUL2, ST_COMB,
    ST_DIV_SETUP, ST_DIV_INT, ST_DIV_FRAC, ST_DIV_DONE, ST_ACC_RD, ST_ACC_WR,
    ST_RD_RD, ST_RD_DIV, ST_RD_OUT, ST_CLR
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product truncated toward zero then shifted by the fraction
  function automatic logic signed [63:0] qtrunc(input logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = m >> FracBits;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction
endpackage

### rtl/core/mesh_tangent_accumulator.sv
// Per-vertex tangent accumulator.
// Input channel in_valid_i/in_stall_o carries one item per beat: load vertex,
// triangle, read tangent or clear. Output channel out_valid_o/out_stall_i
// carries one result beat for each read item, in order.
// A two-entry queue takes input beats while the sequencer works.
// A triangle runs three 64-bit long divisions, one bit a cycle, and the
// single vertex-store read port takes its three corner reads one by one.
// A triangle with a zero determinant skips the divisions.
// Reset empties the queue, drops any pending result and starts a clearing
// sweep that zeroes all sums, counts and degenerate marks before the first
// item runs; a clear item runs the same sweep. Vertex positions are
// undefined until loaded.
// While the receiver stalls, the result is held; the sequencer keeps working
// and waits only when the next read result is ready. The queue keeps
// accepting until full.
module mesh_tangent_accumulator (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  mta_pkg::in_item_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output mta_pkg::out_item_t out_data_o
);
  logic q_valid, q_pop;
  mta_pkg::in_item_t q_data;

  mta_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  mta_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

### rtl/core/mta_front.sv
// Input queue: two entries so the front keeps taking beats while the back works.
module mta_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  mta_pkg::in_item_t in_data_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output mta_pkg::in_item_t q_data_o
);
  mta_pkg::in_item_t mem_q [2];
  logic rp_q, rp_d, wp_q, wp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rp_q];

  always_comb begin
    rp_d = rp_q ^ (q_pop_i && q_valid_o);
    wp_d = wp_q ^ push;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0;
      wp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rp_q <= rp_d;
      wp_q <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule

### rtl/core/mta_back.sv
`include "mesh_tangent_accumulator_assert.svh"
// Sequencer: vertex reads, products, long division, three accumulate passes,
// averaging division, clearing sweep.
module mta_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  mta_pkg::in_item_t q_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output mta_pkg::out_item_t out_data_o
);
  localparam int unsigned IW = mta_pkg::IdxW;
  localparam int unsigned SW = mta_pkg::SumW;
  localparam int unsigned CW = mta_pkg::CntW;

  logic [159:0] vtx_mem [mta_pkg::MaxVertices];
  logic [SW*3+CW:0] acc_mem [mta_pkg::MaxVertices];

  mta_pkg::state_e st_q, st_d;
  mta_pkg::in_item_t it_q;
  logic [159:0] va_q, vb_q, vc_q, vrd_q;
  logic [SW*3+CW:0] arow_q;
  logic [SW*3+CW:0] row_new;
  logic [IW-1:0] vaddr, aaddr;
  logic signed [31:0] d_q [10];
  logic signed [63:0] p_q [8];
  logic signed [63:0] det_q, num_q [3];
  logic [1:0] ax_q, cor_q;
  logic [6:0] bit_q;
  logic [63:0] rem_q, n_q, dmag_q;
  logic [63:0] quo_q, quo_fin;
  logic neg_q, ovf_q;
  logic signed [31:0] t_q [3];
  logic [IW-1:0] clr_q;
  mta_pkg::out_item_t out_q;
  logic ov_q, out_ld;
  logic [SW-1:0] s_sel, smag;
  logic [64:0] rtry;
  logic cnt_ge;

  function automatic logic signed [31:0] df(input logic [31:0] x, input logic [31:0] y);
    return mta_pkg::sat32(65'($signed(x)) - 65'($signed(y)));
  endfunction

  function automatic logic [SW-1:0] sadd(input logic [SW-1:0] s, input logic signed [31:0] t);
    logic signed [SW:0] r;
    r = $signed({s[SW-1], s}) + (SW+1)'(t);
    if (r[SW] != r[SW-1]) return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    return r[SW-1:0];
  endfunction

  assign out_valid_o = ov_q;
  assign out_data_o = out_q;
  // load the result register when it is empty or drains this cycle
  assign out_ld = (st_q == mta_pkg::ST_RD_OUT) && (!ov_q || !out_stall_i);

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      mta_pkg::ST_IDLE:
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_data_i.kind)
            mta_pkg::KIND_LOAD: st_d = mta_pkg::ST_LD;
            mta_pkg::KIND_TRI: st_d = mta_pkg::ST_RDA;
            mta_pkg::KIND_READ: st_d = mta_pkg::ST_RD_RD;
            default: st_d = mta_pkg::ST_CLR;
          endcase
        end
      mta_pkg::ST_LD: st_d = mta_pkg::ST_IDLE;
      mta_pkg::ST_RDA: st_d = mta_pkg::ST_RDB;
      mta_pkg::ST_RDB: st_d = mta_pkg::ST_RDC;
      mta_pkg::ST_RDC: st_d = mta_pkg::ST_DIFF;
      mta_pkg::ST_DIFF: st_d = mta_pkg::ST_MUL;
      mta_pkg::ST_MUL: st_d = mta_pkg::ST_MUL2;
      mta_pkg::ST_MUL2: st_d = mta_pkg::ST_COMB;
      mta_pkg::ST_COMB: st_d = mta_pkg::ST_DIV_SETUP;
      mta_pkg::ST_DIV_SETUP:
        st_d = (det_q == 64'sd0) ? mta_pkg::ST_ACC_RD : mta_pkg::ST_DIV_INT;
      mta_pkg::ST_DIV_INT: if (bit_q == 7'd0) st_d = mta_pkg::ST_DIV_FRAC;
      mta_pkg::ST_DIV_FRAC:
        if (bit_q == 7'd0 || quo_q > (64'd1 << 40)) st_d = mta_pkg::ST_DIV_DONE;
      mta_pkg::ST_DIV_DONE:
        st_d = (ax_q == 2'd2) ? mta_pkg::ST_ACC_RD : mta_pkg::ST_DIV_SETUP;
      mta_pkg::ST_ACC_RD: st_d = mta_pkg::ST_ACC_WR;
      mta_pkg::ST_ACC_WR:
        st_d = (cor_q == 2'd2) ? mta_pkg::ST_IDLE : mta_pkg::ST_ACC_RD;
      mta_pkg::ST_RD_RD: st_d = mta_pkg::ST_RD_DIV;
      mta_pkg::ST_RD_DIV: if (bit_q == 7'd1 && ax_q == 2'd2) st_d = mta_pkg::ST_RD_OUT;
      mta_pkg::ST_RD_OUT: if (!ov_q || !out_stall_i) st_d = mta_pkg::ST_IDLE;
      mta_pkg::ST_CLR: if (clr_q == {IW{1'b1}}) st_d = mta_pkg::ST_IDLE;
      default: st_d = mta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (st_q)
      mta_pkg::ST_RDB: vaddr = it_q.corner_b;
      mta_pkg::ST_RDC: vaddr = it_q.corner_c;
      default: vaddr = it_q.vertex_index;
    endcase
    case (cor_q)
      2'd1: aaddr = it_q.corner_b;
      2'd2: aaddr = it_q.corner_c;
      default: aaddr = it_q.vertex_index;
    endcase
    case (ax_q)
      2'd1: s_sel = arow_q[SW*2+CW:SW+CW+1];
      2'd2: s_sel = arow_q[SW*3+CW:SW*2+CW+1];
      default: s_sel = arow_q[SW+CW:CW+1];
    endcase
    smag = s_sel[SW-1] ? SW'(-s_sel) : s_sel;
    rtry = {rem_q, n_q[63]};
    cnt_ge = (rtry >= 65'(arow_q[CW:1]));
    quo_fin = {quo_q[62:0], cnt_ge};
  end

  always_comb begin
    row_new = arow_q;
    if (arow_q[CW:1] != '1) row_new[CW:1] = arow_q[CW:1] + CW'(1);
    if (det_q == 64'sd0) row_new[0] = 1'b1;
    else begin
      row_new[SW+CW:CW+1] = sadd(arow_q[SW+CW:CW+1], t_q[0]);
      row_new[SW*2+CW:SW+CW+1] = sadd(arow_q[SW*2+CW:SW+CW+1], t_q[1]);
      row_new[SW*3+CW:SW*2+CW+1] = sadd(arow_q[SW*3+CW:SW*2+CW+1], t_q[2]);
    end
  end

  // vertex store and accumulator store: one read port, one write port each
  always_ff @(posedge clk_i) begin
    if (st_q == mta_pkg::ST_LD)
      vtx_mem[it_q.vertex_index] <= {it_q.pos_x, it_q.pos_y, it_q.pos_z,
                                     it_q.tex_u, it_q.tex_v};
    vrd_q <= vtx_mem[vaddr];
    if (st_q == mta_pkg::ST_ACC_WR) acc_mem[aaddr] <= row_new;
    else if (st_q == mta_pkg::ST_CLR) acc_mem[clr_q] <= '0;
    arow_q <= acc_mem[st_q == mta_pkg::ST_RD_RD ? it_q.vertex_index : aaddr];
  end

  // reset starts with a full clearing sweep of the accumulator store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mta_pkg::ST_CLR;
      ov_q <= 1'b0;
      clr_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= out_ld || (ov_q && out_stall_i);
      if (st_q == mta_pkg::ST_CLR) clr_q <= clr_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_data_i;
      ax_q <= 2'd0;
      cor_q <= 2'd0;
    end
    case (st_q)
      mta_pkg::ST_RDB: va_q <= vrd_q;
      mta_pkg::ST_RDC: vb_q <= vrd_q;
      mta_pkg::ST_DIFF: begin
        vc_q <= vrd_q;
      end
      mta_pkg::ST_MUL: begin
        for (int i = 0; i < 5; i++) begin
          d_q[i] <= df(vb_q[i*32 +: 32], va_q[i*32 +: 32]);
          d_q[i+5] <= df(vc_q[i*32 +: 32], va_q[i*32 +: 32]);
        end
      end
      mta_pkg::ST_MUL2: begin
        // d index: 0 v,1 u,2 z,3 y,4 x (b-a); +5 for (c-a)
        p_q[0] <= mta_pkg::qtrunc(64'(d_q[1]) * 64'(d_q[5]));
        p_q[1] <= mta_pkg::qtrunc(64'(d_q[6]) * 64'(d_q[0]));
        p_q[2] <= mta_pkg::qtrunc(64'(d_q[5]) * 64'(d_q[4]));
        p_q[3] <= mta_pkg::qtrunc(64'(d_q[0]) * 64'(d_q[9]));
        p_q[4] <= mta_pkg::qtrunc(64'(d_q[5]) * 64'(d_q[3]));
        p_q[5] <= mta_pkg::qtrunc(64'(d_q[0]) * 64'(d_q[8]));
        p_q[6] <= mta_pkg::qtrunc(64'(d_q[5]) * 64'(d_q[2]));
        p_q[7] <= mta_pkg::qtrunc(64'(d_q[0]) * 64'(d_q[7]));
      end
      mta_pkg::ST_COMB: begin
        det_q <= p_q[0] - p_q[1];
        num_q[0] <= p_q[2] - p_q[3];
        num_q[1] <= p_q[4] - p_q[5];
        num_q[2] <= p_q[6] - p_q[7];
        ax_q <= 2'd0;
        t_q[0] <= '0;
        t_q[1] <= '0;
        t_q[2] <= '0;
      end
      mta_pkg::ST_DIV_SETUP: begin
        n_q <= num_q[ax_q][63] ? 64'(-num_q[ax_q]) : 64'(num_q[ax_q]);
        dmag_q <= det_q[63] ? 64'(-det_q) : 64'(det_q);
        neg_q <= num_q[ax_q][63] ^ det_q[63];
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= 7'd63;
      end
      mta_pkg::ST_DIV_INT, mta_pkg::ST_DIV_FRAC: begin
        if (st_q == mta_pkg::ST_DIV_INT || (bit_q != 7'd0 && quo_q <= (64'd1 << 40))) begin
          if (rtry >= {1'b0, dmag_q}) begin
            rem_q <= 64'(rtry - {1'b0, dmag_q});
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rtry[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          n_q <= {n_q[62:0], 1'b0};
        end
        if (st_q == mta_pkg::ST_DIV_INT && bit_q == 7'd0) bit_q <= 7'(mta_pkg::FracBits);
        else if (bit_q != 7'd0) bit_q <= bit_q - 7'd1;
        ovf_q <= (st_q == mta_pkg::ST_DIV_FRAC) && bit_q != 7'd0 && quo_q > (64'd1 << 40);
      end
      mta_pkg::ST_DIV_DONE: begin
        if (ovf_q || quo_q > (neg_q ? 64'h80000000 : 64'h7FFFFFFF))
          t_q[ax_q] <= neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
        else t_q[ax_q] <= neg_q ? -$signed(quo_q[31:0]) : $signed(quo_q[31:0]);
        ax_q <= ax_q + 2'd1;
      end
      mta_pkg::ST_ACC_WR: cor_q <= cor_q + 2'd1;
      mta_pkg::ST_RD_RD: begin
        ax_q <= 2'd0;
        bit_q <= 7'd0;
      end
      mta_pkg::ST_RD_DIV: begin
        // restoring division of |sum| by count, one bit a cycle per axis
        if (bit_q == 7'd0) begin
          n_q <= {smag, {(64-SW){1'b0}}};
          rem_q <= '0;
          quo_q <= '0;
          bit_q <= 7'(SW);
        end else begin
          if (cnt_ge) rem_q <= 64'(rtry - 65'(arow_q[CW:1]));
          else rem_q <= rtry[63:0];
          quo_q <= quo_fin;
          n_q <= {n_q[62:0], 1'b0};
          bit_q <= bit_q - 7'd1;
          // last bit of this axis: sign the average and advance
          if (bit_q == 7'd1) begin
            if (arow_q[CW:1] == '0) t_q[ax_q] <= '0;
            else t_q[ax_q] <= mta_pkg::sat32(s_sel[SW-1] ?
                -$signed({1'b0, quo_fin}) : $signed({1'b0, quo_fin}));
            ax_q <= ax_q + 2'd1;
          end
        end
      end
      default: ;
    endcase
    if (out_ld) begin
      out_q.read_index <= it_q.vertex_index;
      out_q.tangent_x <= t_q[0];
      out_q.tangent_y <= t_q[1];
      out_q.tangent_z <= t_q[2];
      out_q.use_count <= arow_q[CW:1];
      out_q.degenerate_seen <= arow_q[0];
    end
  end

  `MTA_ASSERT(a_pop_idle, clk_i, rst_ni, !q_pop_o || st_q == mta_pkg::ST_IDLE,
              "pop outside idle")
  `MTA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ov_q && out_stall_i,
                   ov_q && $stable(out_q), "result dropped or changed under stall")
  `MTA_ASSERT_NEXT(a_rd_out, clk_i, rst_ni, out_ld, ov_q,
                   "read produced no result")
endmodule
